// ===== design/dbs_pkg.sv =====
// ----------------------------------------------------------------------------
// dbs_pkg
// Shared widths, register map and reset values of the disparity boundary
// strength block.
// ----------------------------------------------------------------------------
package dbs_pkg;

    localparam int DISP_W      = 16;
    localparam int COL_OUT_W   = 11;
    localparam int ROW_OUT_W   = 11;
    localparam int BND_LSB     = 0;
    localparam int COL_LSB     = DISP_W;
    localparam int ROW_LSB     = DISP_W + COL_OUT_W;
    localparam int OUT_USED_W  = DISP_W + COL_OUT_W + ROW_OUT_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int PAD_W       = OUT_TDATA_W - OUT_USED_W;

    localparam int SIZE_W      = 12;
    localparam int CFG_AW      = 4;
    localparam int CFG_DW      = 32;
    localparam int REG_IDX_W   = 2;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [DISP_W-1:0]    disp_t;
    typedef logic [SIZE_W-1:0]    size_t;

    localparam reg_idx_t REG_IMAGE_WIDTH  = 2'd0;
    localparam reg_idx_t REG_IMAGE_HEIGHT = 2'd1;
    localparam reg_idx_t REG_SCORE_OFFSET = 2'd2;
    localparam reg_idx_t REG_CLAMP_LIMIT  = 2'd3;

    localparam size_t WIDTH_RST  = 12'd640;
    localparam size_t HEIGHT_RST = 12'd480;
    localparam disp_t OFFSET_RST = 16'd48;
    localparam disp_t CLAMP_RST  = 16'd160;

endpackage

// ===== design/disparity_boundary_strength.sv =====
// ----------------------------------------------------------------------------
// disparity_boundary_strength
// Boundary strength of a raster-order disparity stream, RADIUS rows late.
// ----------------------------------------------------------------------------
// Usage:
//   s_* takes one disparity word per pixel in raster order; s_tuser set marks
//   column 0 of row 0 of a new image. m_* gives result words: boundary,
//   column and row of the pixel, m_tlast on the final word caused by an input.
//   An input at row r >= RADIUS yields the result for row r - RADIUS; an input
//   on the last row also flushes the remaining rows of that column, so such a
//   pixel yields up to RADIUS + 1 words on consecutive cycles while m_tready is high.
//   A taken input passes registered stages 1, 2, 3 and 4; m_tdata is stage 4.
//   Throughput: one pixel per cycle while m_tready is high; a pixel on the
//   last row holds the output stage until each word it yields is taken.
//   Row store: 2*RADIUS banks of MAX_WIDTH words, one write and two reads per
//   cycle, which set the one-pixel-per-cycle figure.
//   Reset clears position to (0, 0), empties the pipeline and loads register
//   defaults; the row store is not cleared and needs no sweep.
//   A stalled m_tready holds the output word; the four pipeline stages keep
//   taking input until they are full, then s_tready drops.
//   Registers (APB, byte address 4*i): image_width, image_height,
//   score_offset, clamp_limit. Write only while the block is idle.
// ----------------------------------------------------------------------------
module disparity_boundary_strength #(
    parameter int RADIUS     = 3,
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dbs_pkg::DISP_W-1:0]      s_tdata,   // [15:0] disparity
    input  logic                            s_tuser,   // [0] frame_start
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [dbs_pkg::OUT_TDATA_W-1:0] m_tdata,   // boundary, pixel_column, pixel_row, pad
    output logic                            m_tlast,   // last_of_run
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [dbs_pkg::CFG_AW-1:0]      paddr,
    input  logic [dbs_pkg::CFG_DW-1:0]      pwdata,
    output logic [dbs_pkg::CFG_DW-1:0]      prdata,
    output logic                            pready
);

    import dbs_pkg::*;

    localparam int RING = 2 * RADIUS;
    localparam int SW   = $clog2(RING);
    localparam int CW   = $clog2(MAX_WIDTH + 1);
    localparam int RW   = $clog2(MAX_HEIGHT + 1);
    localparam int AW   = $clog2(MAX_WIDTH);
    localparam int NW   = $clog2(RADIUS + 2);

    localparam logic [SIZE_W:0] MAXW_CMP = (SIZE_W + 1)'(MAX_WIDTH);
    localparam logic [SIZE_W:0] MAXH_CMP = (SIZE_W + 1)'(MAX_HEIGHT);

    // ---------------- configuration ----------------
    size_t    width_cfg_reg;
    size_t    height_cfg_reg;
    disp_t    offset_cfg_reg;
    disp_t    clamp_cfg_reg;
    reg_idx_t reg_idx;
    logic     cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_AW-1:2];
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_cfg_reg  <= WIDTH_RST;
            height_cfg_reg <= HEIGHT_RST;
            offset_cfg_reg <= OFFSET_RST;
            clamp_cfg_reg  <= CLAMP_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH:  width_cfg_reg  <= pwdata[SIZE_W-1:0];
                REG_IMAGE_HEIGHT: height_cfg_reg <= pwdata[SIZE_W-1:0];
                REG_SCORE_OFFSET: offset_cfg_reg <= pwdata[DISP_W-1:0];
                REG_CLAMP_LIMIT:  clamp_cfg_reg  <= pwdata[DISP_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = CFG_DW'(width_cfg_reg);
            REG_IMAGE_HEIGHT: prdata = CFG_DW'(height_cfg_reg);
            REG_SCORE_OFFSET: prdata = CFG_DW'(offset_cfg_reg);
            REG_CLAMP_LIMIT:  prdata = CFG_DW'(clamp_cfg_reg);
        endcase
    end

    // effective sizes: 0 acts as 1, above maximum acts as maximum
    logic [CW-1:0] img_w;
    logic [RW-1:0] img_h;

    always_comb
    begin
        if (width_cfg_reg == '0)
            img_w = CW'(1);
        else if ({1'b0, width_cfg_reg} > MAXW_CMP)
            img_w = CW'(MAX_WIDTH);
        else
            img_w = CW'(width_cfg_reg);

        if (height_cfg_reg == '0)
            img_h = RW'(1);
        else if ({1'b0, height_cfg_reg} > MAXH_CMP)
            img_h = RW'(MAX_HEIGHT);
        else
            img_h = RW'(height_cfg_reg);
    end

    // ---------------- position and stage 0 ----------------
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [SW-1:0] slot_reg, slot_next;

    logic [CW-1:0] pos_c;
    logic [RW-1:0] pos_r;
    logic [SW-1:0] pos_s;
    logic [CW:0]   look_col;
    logic          is_main;
    logic          is_flush;
    logic          interior;
    logic [NW-1:0] cnt0;
    logic [RW-1:0] base0;
    logic          accept;

    logic ld1, ld2, ld3, ld4;

    assign s_tready = ld1;
    assign accept   = s_tvalid & ld1;

    always_comb
    begin
        pos_c = s_tuser ? '0 : col_reg;
        pos_r = s_tuser ? '0 : row_reg;
        pos_s = s_tuser ? '0 : slot_reg;
        if (pos_c >= img_w)
        begin
            pos_c = '0;
            pos_r = pos_r + RW'(1);
            pos_s = (pos_s == SW'(RING - 1)) ? '0 : pos_s + SW'(1);
        end
        if (pos_r >= img_h)
        begin
            pos_r = '0;
            pos_s = '0;
        end

        col_next  = pos_c + CW'(1);
        row_next  = pos_r;
        slot_next = pos_s;
        if (col_next >= img_w)
        begin
            col_next  = '0;
            row_next  = pos_r + RW'(1);
            slot_next = (pos_s == SW'(RING - 1)) ? '0 : pos_s + SW'(1);
            if (row_next >= img_h)
            begin
                row_next  = '0;
                slot_next = '0;
            end
        end

        look_col = (CW + 1)'(pos_c) + (CW + 1)'(RADIUS);
        is_main  = pos_r >= RW'(RADIUS);
        is_flush = (pos_r + RW'(1)) == img_h;
        interior = is_main && (pos_r >= RW'(RING)) && (pos_c >= CW'(RADIUS))
                   && (look_col < (CW + 1)'(img_w));
        if (is_main)
        begin
            cnt0  = is_flush ? NW'(RADIUS + 1) : NW'(1);
            base0 = pos_r - RW'(RADIUS);
        end
        else
        begin
            cnt0  = is_flush ? NW'(pos_r) + NW'(1) : '0;
            base0 = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            slot_reg <= '0;
        end
        else if (accept)
        begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            slot_reg <= slot_next;
        end
    end

    // ---------------- row store ----------------
    disp_t rd_a [RING];
    disp_t rd_b [RING];

    generate
        for (genvar b = 0; b < RING; b++)
        begin : g_bank
            dbs_ram #(
                .WIDTH (DISP_W),
                .DEPTH (MAX_WIDTH)
            ) u_ram (
                .clk     (clk),
                .we      (accept && (pos_s == SW'(b))),
                .waddr   (pos_c[AW-1:0]),
                .wdata   (s_tdata),
                .re      (accept),
                .raddr_a (pos_c[AW-1:0]),
                .raddr_b (look_col[AW-1:0]),
                .rdata_a (rd_a[b]),
                .rdata_b (rd_b[b])
            );
        end
    endgenerate

    // ---------------- stage 1: neighbour selection ----------------
    logic          v1_reg;
    disp_t         cur1_reg;
    logic [SW-1:0] slot1_reg;
    logic          int1_reg;
    logic [CW-1:0] col1_reg;
    logic [RW-1:0] base1_reg;
    logic [NW-1:0] cnt1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (ld1)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cur1_reg  <= s_tdata;
            slot1_reg <= pos_s;
            int1_reg  <= interior;
            col1_reg  <= pos_c;
            base1_reg <= base0;
            cnt1_reg  <= cnt0;
        end
    end

    disp_t vert [RING];
    disp_t center_d;
    disp_t look_d;
    disp_t lhist_reg [RADIUS];
    disp_t right_v [RADIUS];
    disp_t ah_next, bh_next, av_next, bv_next;
    logic  hist_shift;

    assign hist_shift = v1_reg & ld2;

    // vert[d] holds the current column of row (input row - d), vert[0] that of row - RING
    always_comb
    begin
        int idx;
        int lidx;
        for (int d = 0; d < RING; d++)
        begin
            idx = int'(slot1_reg) + RING - d;
            if (idx >= RING)
                idx = idx - RING;
            vert[d] = rd_a[SW'(idx)];
        end
        lidx = int'(slot1_reg) + RADIUS;
        if (lidx >= RING)
            lidx = lidx - RING;
        look_d   = rd_b[SW'(lidx)];
        center_d = vert[RADIUS];
    end

    assign right_v[RADIUS-1] = look_d;

    generate
        if (RADIUS > 1)
        begin : g_rhist
            disp_t rhist_reg [RADIUS-1];

            always_ff @(posedge clk)
            begin
                if (hist_shift)
                begin
                    rhist_reg[0] <= look_d;
                    for (int j = 1; j < RADIUS - 1; j++)
                        rhist_reg[j] <= rhist_reg[j-1];
                end
            end

            for (genvar k = 1; k < RADIUS; k++)
            begin : g_right
                assign right_v[k-1] = rhist_reg[RADIUS-1-k];
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (hist_shift)
        begin
            lhist_reg[0] <= center_d;
            for (int j = 1; j < RADIUS; j++)
                lhist_reg[j] <= lhist_reg[j-1];
        end
    end

    // nearest valid neighbour on each side
    always_comb
    begin
        disp_t below_k;
        ah_next = '0;
        bh_next = '0;
        av_next = '0;
        bv_next = '0;
        for (int k = RADIUS; k >= 1; k--)
        begin
            if (lhist_reg[k-1] != '0)
                ah_next = lhist_reg[k-1];
            if (right_v[k-1] != '0)
                bh_next = right_v[k-1];
            if (vert[(RADIUS + k) % RING] != '0)
                av_next = vert[(RADIUS + k) % RING];
            below_k = (k == RADIUS) ? cur1_reg : vert[(RADIUS - k) % RING];
            if (below_k != '0)
                bv_next = below_k;
        end
    end

    // ---------------- stage 2: clamped differences ----------------
    logic          v2_reg;
    disp_t         ah2_reg, bh2_reg, av2_reg, bv2_reg;
    logic          int2_reg;
    logic [CW-1:0] col2_reg;
    logic [RW-1:0] base2_reg;
    logic [NW-1:0] cnt2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (ld2)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (hist_shift)
        begin
            ah2_reg   <= ah_next;
            bh2_reg   <= bh_next;
            av2_reg   <= av_next;
            bv2_reg   <= bv_next;
            int2_reg  <= int1_reg;
            col2_reg  <= col1_reg;
            base2_reg <= base1_reg;
            cnt2_reg  <= cnt1_reg;
        end
    end

    disp_t dh_raw, dv_raw, dh_next, dv_next;
    logic  okh_next, okv_next;

    always_comb
    begin
        dh_raw   = (ah2_reg > bh2_reg) ? ah2_reg - bh2_reg : bh2_reg - ah2_reg;
        dv_raw   = (av2_reg > bv2_reg) ? av2_reg - bv2_reg : bv2_reg - av2_reg;
        dh_next  = (dh_raw > clamp_cfg_reg) ? clamp_cfg_reg : dh_raw;
        dv_next  = (dv_raw > clamp_cfg_reg) ? clamp_cfg_reg : dv_raw;
        okh_next = int2_reg && (ah2_reg != '0) && (bh2_reg != '0);
        okv_next = int2_reg && (av2_reg != '0) && (bv2_reg != '0);
    end

    // ---------------- stage 3: offset and maximum ----------------
    logic          v3_reg;
    disp_t         dh3_reg, dv3_reg;
    logic          okh3_reg, okv3_reg;
    logic [CW-1:0] col3_reg;
    logic [RW-1:0] base3_reg;
    logic [NW-1:0] cnt3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (ld3)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ld3 && v2_reg)
        begin
            dh3_reg   <= dh_next;
            dv3_reg   <= dv_next;
            okh3_reg  <= okh_next;
            okv3_reg  <= okv_next;
            col3_reg  <= col2_reg;
            base3_reg <= base2_reg;
            cnt3_reg  <= cnt2_reg;
        end
    end

    disp_t sh, sv, bnd_next;

    always_comb
    begin
        sh       = (okh3_reg && (dh3_reg > offset_cfg_reg)) ? dh3_reg - offset_cfg_reg : '0;
        sv       = (okv3_reg && (dv3_reg > offset_cfg_reg)) ? dv3_reg - offset_cfg_reg : '0;
        bnd_next = (sh > sv) ? sh : sv;
    end

    // ---------------- stage 4: output words ----------------
    logic          v4_reg;
    logic [NW-1:0] beat4_reg;
    disp_t         bnd4_reg;
    logic [CW-1:0] col4_reg;
    logic [RW-1:0] base4_reg;
    logic [NW-1:0] cnt4_reg;
    logic          last_beat;
    logic [RW-1:0] row_out;
    disp_t         bnd_out;

    assign last_beat = beat4_reg == (cnt4_reg - NW'(1));
    assign ld4       = !v4_reg || (m_tready && last_beat);
    assign ld3       = !v3_reg || ld4;
    assign ld2       = !v2_reg || ld3;
    assign ld1       = !v1_reg || ld2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg    <= 1'b0;
            beat4_reg <= '0;
        end
        else if (ld4)
        begin
            v4_reg    <= v3_reg && (cnt3_reg != '0);
            beat4_reg <= '0;
        end
        else if (m_tready)
        begin
            beat4_reg <= beat4_reg + NW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld4 && v3_reg)
        begin
            bnd4_reg  <= bnd_next;
            col4_reg  <= col3_reg;
            base4_reg <= base3_reg;
            cnt4_reg  <= cnt3_reg;
        end
    end

    // flushed rows follow the main row and always carry zero
    assign row_out = base4_reg + RW'(beat4_reg);
    assign bnd_out = (beat4_reg == '0) ? bnd4_reg : '0;

    assign m_tvalid = v4_reg;
    assign m_tlast  = last_beat;
    assign m_tdata  = {{PAD_W{1'b0}}, ROW_OUT_W'(row_out), COL_OUT_W'(col4_reg), bnd_out};

endmodule

// ===== design/dbs_ram.sv =====
// ----------------------------------------------------------------------------
// dbs_ram
// Generic RAM: one write port, two read ports, registered read data
// (read-before-write on a colliding address).
// ----------------------------------------------------------------------------
module dbs_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 2048,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_a,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a <= mem_reg[raddr_a];
            rdata_b <= mem_reg[raddr_b];
        end
    end

endmodule

// ===== design/dbs_checker.sv =====
// ----------------------------------------------------------------------------
// dbs_checker
// Port-level assertions for the disparity boundary strength block.
// ----------------------------------------------------------------------------
module dbs_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [dbs_pkg::DISP_W-1:0]      s_tdata,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [dbs_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic                            m_tlast,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [dbs_pkg::CFG_AW-1:0]      paddr,
    input logic [dbs_pkg::CFG_DW-1:0]      pwdata,
    input logic [dbs_pkg::CFG_DW-1:0]      prdata,
    input logic                            pready
);

    import dbs_pkg::*;

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // rest of a run is ready straight away
    a_run_cont: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("run broken before its last word");

    // flushed words: same column, next row, zero strength
    a_run_rows: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            (m_tdata[ROW_LSB +: ROW_OUT_W] == $past(m_tdata[ROW_LSB +: ROW_OUT_W]) + 11'd1)
            && (m_tdata[COL_LSB +: COL_OUT_W] == $past(m_tdata[COL_LSB +: COL_OUT_W]))
            && (m_tdata[BND_LSB +: DISP_W] == '0))
        else $error("flushed word out of sequence");

    // register readback
    a_cfg_read: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready) ##1 (psel && !pwrite && (paddr == $past(paddr)))
            |-> prdata[SIZE_W-1:0] == $past(pwdata[SIZE_W-1:0]))
        else $error("register readback mismatch");

endmodule

bind disparity_boundary_strength dbs_checker u_dbs_checker (.*);
